// ===== design/lru_key_value_cache_macros.svh =====
// Assertion helpers for the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Condition and consequence in the same cycle.
`define LKVC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the cycle after the condition.
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lkvc_pkg.sv =====
package lkvc_pkg;

   // Fixed field widths.
   localparam int CAP_W = 5;
   localparam int KEY_W = 32;
   localparam int VAL_W = 31;
   localparam int OUT_W = 32;

   // Default store depth and capacity after reset.
   localparam int ENTRIES_DEF = 16;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Operation codes.
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Result word handed from the controller to the output register.
   typedef struct packed {
      logic             load;
      logic             hit;
      logic [OUT_W-1:0] value;
   } rsp_load_type;

endpackage

// ===== design/lkvc_if.sv =====
// Request channel: one get or put per word.
interface lkvc_req_if;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [lkvc_pkg::KEY_W-1:0] key;
   logic [lkvc_pkg::VAL_W-1:0] value_in;

   modport source (output valid, output op, output key, output value_in, input ready);
   modport sink   (input valid, input op, input key, input value_in, output ready);
endinterface

// Result channel: one word per get.
interface lkvc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              hit;
   logic signed [lkvc_pkg::OUT_W-1:0] value_out;

   modport source (output valid, output hit, output value_out, input ready);
   modport sink   (input valid, input hit, input value_out, output ready);
endinterface

// Capacity register write channel.
interface lkvc_csr_if;
   logic                       valid;
   logic                       ready;
   logic [lkvc_pkg::CAP_W-1:0] capacity;

   modport source (output valid, output capacity, input ready);
   modport sink   (input valid, input capacity, output ready);
endinterface

// ===== design/lkvc_ram.sv =====
module lkvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lkvc_ctrl.sv =====
module lkvc_ctrl #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF,
   parameter int CNT_W = $clog2(ENTRIES + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   lkvc_req_if.sink                   req,
   input  logic [lkvc_pkg::CAP_W-1:0] capacity,
   input  logic                       rsp_free,
   output lkvc_pkg::rsp_load_type     rsp_load,
   output logic [CNT_W-1:0]           occ_count
);

   import lkvc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int DATA_W = KEY_W + VAL_W + RANK_W;
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CMP_W-1:0] ENT_CMP = CMP_W'(ENTRIES);
   localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;

   // Latched request.
   logic              op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [VAL_W-1:0]  val_ff, val_in;

   // Read issue pointer and the stage that sees the read data.
   logic              rd_on_ff, rd_on_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              stg_vld_ff, stg_vld_in;
   logic [IDX_W-1:0]  stg_idx_ff, stg_idx_in;

   // Scan results.
   logic              hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [RANK_W-1:0] hit_rank_ff, hit_rank_in;
   logic [VAL_W-1:0]  hit_val_ff, hit_val_in;
   logic              old_found_ff, old_found_in;
   logic [IDX_W-1:0]  old_idx_ff, old_idx_in;
   logic [RANK_W-1:0] old_rank_ff, old_rank_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;

   // Update pass mode and the slot an insert goes to.
   logic              insert_ff, insert_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;

   // Per-entry valid bits and occupancy.
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;

   // Memory port signals.
   logic              ram_we;
   logic [DATA_W-1:0] ram_wdata;
   logic [DATA_W-1:0] ram_rdata;

   // Fields of the entry in the stage.
   logic [KEY_W-1:0]  e_key;
   logic [VAL_W-1:0]  e_val;
   logic [RANK_W-1:0] e_rank;
   logic              e_valid;

   // Eviction decision terms.
   logic [CMP_W-1:0]  cap_cmp;
   logic [CMP_W-1:0]  eff_cap;
   logic [CMP_W-1:0]  occ_cmp;
   logic              evict;
   logic [IDX_W-1:0]  new_slot;

   lkvc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ENTRIES),
      .ADDR_W(IDX_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(stg_idx_ff),
      .wr_data(ram_wdata),
      .rd_addr(rd_idx_ff),
      .rd_data(ram_rdata)
   );

   assign e_key = ram_rdata[DATA_W-1 -: KEY_W];
   assign e_val = ram_rdata[RANK_W +: VAL_W];
   assign e_rank = ram_rdata[RANK_W-1:0];
   assign e_valid = valid_ff[stg_idx_ff];

   // Effective capacity is clamped to 1..ENTRIES.
   always_comb begin
      cap_cmp = CMP_W'(capacity);
      occ_cmp = CMP_W'(occ_ff);
      priority if (cap_cmp == '0) begin
         eff_cap = ONE_CMP;
      end else if (cap_cmp > ENT_CMP) begin
         eff_cap = ENT_CMP;
      end else begin
         eff_cap = cap_cmp;
      end
      evict = old_found_ff && ((occ_cmp >= eff_cap) || (occ_cmp == ENT_CMP));
      new_slot = (evict && (!free_found_ff || (old_idx_ff < free_idx_ff))) ?
                 old_idx_ff : free_idx_ff;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign occ_count = occ_ff;

   // Next-state logic for the scan, decision and update passes.
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      key_in = key_ff;
      val_in = val_ff;
      rd_on_in = rd_on_ff;
      rd_idx_in = rd_idx_ff;
      stg_vld_in = rd_on_ff;
      stg_idx_in = rd_idx_ff;
      hit_found_in = hit_found_ff;
      hit_idx_in = hit_idx_ff;
      hit_rank_in = hit_rank_ff;
      hit_val_in = hit_val_ff;
      old_found_in = old_found_ff;
      old_idx_in = old_idx_ff;
      old_rank_in = old_rank_ff;
      free_found_in = free_found_ff;
      free_idx_in = free_idx_ff;
      insert_in = insert_ff;
      slot_in = slot_ff;
      valid_in = valid_ff;
      occ_in = occ_ff;
      ram_we = 1'b0;
      ram_wdata = ram_rdata;
      rsp_load = '0;

      // Walk the read pointer across the memory once per pass.
      if (rd_on_ff) begin
         rd_idx_in = rd_idx_ff + 1'b1;
         if (rd_idx_ff == LAST_IDX) begin
            rd_on_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               op_in = req.op;
               key_in = req.key;
               val_in = req.value_in;
               rd_on_in = 1'b1;
               rd_idx_in = '0;
               hit_found_in = 1'b0;
               old_found_in = 1'b0;
               free_found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (stg_vld_ff) begin
               // Key match, oldest entry and first free slot.
               if (e_valid && (e_key == key_ff) && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in = stg_idx_ff;
                  hit_rank_in = e_rank;
                  hit_val_in = e_val;
               end
               if (e_valid && (!old_found_ff || (e_rank > old_rank_ff))) begin
                  old_found_in = 1'b1;
                  old_idx_in = stg_idx_ff;
                  old_rank_in = e_rank;
               end
               if (!e_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in = stg_idx_ff;
               end
               if (stg_idx_ff == LAST_IDX) begin
                  state_in = ST_DECIDE;
               end
            end
         end

         ST_DECIDE: begin
            if (op_ff == OP_GET) begin
               // A get waits here until the output register can take its word.
               if (rsp_free) begin
                  rsp_load.load = 1'b1;
                  rsp_load.hit = hit_found_ff;
                  rsp_load.value = hit_found_ff ? {1'b0, hit_val_ff} : '1;
                  if (hit_found_ff) begin
                     insert_in = 1'b0;
                     rd_on_in = 1'b1;
                     rd_idx_in = '0;
                     state_in = ST_UPDATE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end else if (hit_found_ff) begin
               insert_in = 1'b0;
               rd_on_in = 1'b1;
               rd_idx_in = '0;
               state_in = ST_UPDATE;
            end else if (evict || free_found_ff) begin
               // Evict the oldest entry if needed, then claim the slot.
               if (evict) begin
                  valid_in[old_idx_ff] = 1'b0;
               end else begin
                  occ_in = occ_ff + 1'b1;
               end
               valid_in[new_slot] = 1'b1;
               slot_in = new_slot;
               insert_in = 1'b1;
               rd_on_in = 1'b1;
               rd_idx_in = '0;
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_UPDATE: begin
            if (stg_vld_ff) begin
               if (insert_ff) begin
                  // Insert: new pair is youngest, every other live entry ages.
                  if (stg_idx_ff == slot_ff) begin
                     ram_we = 1'b1;
                     ram_wdata = {key_ff, val_ff, {RANK_W{1'b0}}};
                  end else if (e_valid) begin
                     ram_we = 1'b1;
                     ram_wdata = {e_key, e_val, e_rank + 1'b1};
                  end
               end else begin
                  // Touch: entries younger than the hit age by one.
                  if (stg_idx_ff == hit_idx_ff) begin
                     ram_we = 1'b1;
                     ram_wdata = {e_key, (op_ff == OP_PUT) ? val_ff : e_val,
                                  {RANK_W{1'b0}}};
                  end else if (e_valid && (e_rank < hit_rank_ff)) begin
                     ram_we = 1'b1;
                     ram_wdata = {e_key, e_val, e_rank + 1'b1};
                  end
               end
               if (stg_idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rd_on_ff <= 1'b0;
         stg_vld_ff <= 1'b0;
         valid_ff <= '0;
         occ_ff <= '0;
      end else begin
         state_ff <= state_in;
         rd_on_ff <= rd_on_in;
         stg_vld_ff <= stg_vld_in;
         valid_ff <= valid_in;
         occ_ff <= occ_in;
      end
      op_ff <= op_in;
      key_ff <= key_in;
      val_ff <= val_in;
      rd_idx_ff <= rd_idx_in;
      stg_idx_ff <= stg_idx_in;
      hit_found_ff <= hit_found_in;
      hit_idx_ff <= hit_idx_in;
      hit_rank_ff <= hit_rank_in;
      hit_val_ff <= hit_val_in;
      old_found_ff <= old_found_in;
      old_idx_ff <= old_idx_in;
      old_rank_ff <= old_rank_in;
      free_found_ff <= free_found_in;
      free_idx_ff <= free_idx_in;
      insert_ff <= insert_in;
      slot_ff <= slot_in;
   end

endmodule

// ===== design/lru_key_value_cache.sv =====
// Channel  Direction  Word                         Handshake
// req      in         op, key, value_in            req.valid / req.ready
// rsp      out        hit, value_out (get only)    rsp.valid / rsp.ready
// csr      in         capacity                     csr.valid / csr.ready
//
// One request at a time. Each request makes one scan pass over the single entry
// memory to find the key, the oldest entry and a free slot; every request but a
// get that misses then makes one read-modify-write pass that updates the recency
// ranks, and the next request is taken only after that. Reset is synchronous and
// clears the valid bits and occupancy at once; no clearing pass follows. A stalled
// rsp holds its word in the output register; the block keeps working until its
// next get result.
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lkvc_req_if.sink   req,
   lkvc_rsp_if.source rsp,
   lkvc_csr_if.sink   csr
);

   import lkvc_pkg::*;

   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [CAP_W-1:0] capacity_ff;
   logic             rsp_valid_ff;
   logic             rsp_hit_ff;
   logic [OUT_W-1:0] rsp_value_ff;
   logic             rsp_free;
   rsp_load_type     rsp_load;
   logic [CNT_W-1:0] occ_count;

   // Capacity register, always writable.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr.valid) begin
         capacity_ff <= csr.capacity;
      end
   end

   lkvc_ctrl #(
      .ENTRIES(ENTRIES),
      .CNT_W  (CNT_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .capacity (capacity_ff),
      .rsp_free (rsp_free),
      .rsp_load (rsp_load),
      .occ_count(occ_count)
   );

   // Output register between the controller and the result channel.
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load.load) begin
         rsp_hit_ff <= rsp_load.hit;
         rsp_value_ff <= rsp_load.value;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.hit = rsp_hit_ff;
   assign rsp.value_out = rsp_value_ff;

   // A new result never overwrites one that has not been taken.
   `LKVC_ASSERT_NOW(a_no_overwrite, rsp_load.load && rsp_valid_ff, rsp.ready, "result overwritten")
   // Occupancy stays within the store depth.
   `LKVC_ASSERT_NOW(a_occ_bound, 1'b1, occ_count <= ENTRIES, "occupancy above depth")
   // An accepted request keeps the block busy for at least the next cycle.
   `LKVC_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
   // A miss always carries the all-ones value.
   `LKVC_ASSERT_NOW(a_miss_value, rsp_load.load && !rsp_load.hit, rsp_load.value == '1, "bad miss value")

endmodule

// ===== tb/lru_key_value_cache_tb.sv =====
`timescale 1ns / 100ps

import lkvc_pkg::*;

// One get reply as the cache should return it.
typedef struct packed {
   logic             hit;
   logic [OUT_W-1:0] value;
} cache_reply_type;

// Shadow copy of the cache contents plus the queue of replies still owed by the block.
class lru_cache_scoreboard;
   logic [CAP_W-1:0] cap_reg;
   bit               slot_used [ENTRIES_DEF];
   logic [KEY_W-1:0] slot_key  [ENTRIES_DEF];
   logic [VAL_W-1:0] slot_val  [ENTRIES_DEF];
   int unsigned      slot_age  [ENTRIES_DEF];
   int unsigned      fill_count;
   cache_reply_type  pending_replies[$];
   int unsigned      fault_count;

   function new();
      cap_reg    = CAP_RESET;
      fill_count = 0;
      fault_count = 0;
      foreach (slot_used[i]) begin
         slot_used[i] = 1'b0;
         slot_age[i]  = 0;
      end
   endfunction

   // Only the first ten failures are printed; the rest are just counted.
   function void flag(string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%0t ns: %s", $time, msg);
      end
   endfunction

   // A capacity of zero acts as one, and anything above the store depth as the depth.
   function int unsigned usable_slots();
      int unsigned c;
      c = cap_reg;
      if (c == 0) begin
         c = 1;
      end
      if (c > ENTRIES_DEF) begin
         c = ENTRIES_DEF;
      end
      return c;
   endfunction

   function int find_slot(logic [KEY_W-1:0] k);
      int found;
      found = -1;
      foreach (slot_used[i]) begin
         if (found < 0 && slot_used[i] && slot_key[i] == k) begin
            found = i;
         end
      end
      return found;
   endfunction

   // Entry e becomes the youngest; every entry younger than it ages by one.
   function void promote(int e);
      int unsigned r;
      r = slot_age[e];
      foreach (slot_used[i]) begin
         if (slot_used[i] && slot_age[i] < r) begin
            slot_age[i]++;
         end
      end
      slot_age[e] = 0;
   endfunction

   // A new key evicts the oldest entry once occupancy reaches the capacity or the
   // store is full. A lowered capacity never drops more than one entry per put.
   function void insert_pair(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int victim;
      int spot;
      victim = -1;
      spot   = -1;
      if (fill_count >= usable_slots() || fill_count >= ENTRIES_DEF) begin
         foreach (slot_used[i]) begin
            if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) begin
               victim = i;
            end
         end
         if (victim >= 0) begin
            slot_used[victim] = 1'b0;
            slot_age[victim]  = 0;
            fill_count--;
         end
      end
      foreach (slot_used[i]) begin
         if (spot < 0 && !slot_used[i]) begin
            spot = i;
         end
      end
      if (spot < 0) begin
         return;
      end
      foreach (slot_used[i]) begin
         if (slot_used[i]) begin
            slot_age[i]++;
         end
      end
      slot_used[spot] = 1'b1;
      slot_key[spot]  = k;
      slot_val[spot]  = v;
      slot_age[spot]  = 0;
      fill_count++;
   endfunction

   function void note_capacity(logic [CAP_W-1:0] c);
      cap_reg = c;
   endfunction

   // Called for every accepted request word.
   function void note_request(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int e;
      cache_reply_type reply;
      e = find_slot(k);
      if (op == OP_GET) begin
         if (e >= 0) begin
            promote(e);
            reply.hit   = 1'b1;
            reply.value = {1'b0, slot_val[e]};
         end else begin
            reply.hit   = 1'b0;
            reply.value = '1;
         end
         pending_replies.push_back(reply);
      end else if (e >= 0) begin
         promote(e);
         slot_val[e] = v;
      end else begin
         insert_pair(k, v);
      end
   endfunction

   // Called for every accepted reply word; compares it with the oldest expectation.
   function void check_reply(logic hit, logic [OUT_W-1:0] value);
      cache_reply_type want;
      if (pending_replies.size() == 0) begin
         flag($sformatf("reply with none pending: hit=%0b value=%h", hit, value));
         return;
      end
      want = pending_replies.pop_front();
      if (hit !== want.hit) begin
         flag($sformatf("hit mismatch: expected %0b, got %0b", want.hit, hit));
      end
      if (value !== want.value) begin
         flag($sformatf("value_out mismatch: expected %h, got %h", want.value, value));
      end
   endfunction

   function void check_drained();
      foreach (pending_replies[i]) begin
         flag($sformatf("reply never arrived: hit=%0b value=%h",
                        pending_replies[i].hit, pending_replies[i].value));
      end
      pending_replies.delete();
   endfunction
endclass

module lru_key_value_cache_tb;

   localparam int SETTLE_CYCLES = 2 * ENTRIES_DEF + 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AT_WORD  = 500;
   localparam int PHASE_ITEMS   = 135;
   localparam int POOL_SIZE     = 20;

   logic clock = 1'b0;
   logic reset;

   lkvc_req_if req_if ();
   lkvc_rsp_if rsp_if ();
   lkvc_csr_if csr_if ();

   lru_key_value_cache #(
      .ENTRIES(ENTRIES_DEF)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if),
      .csr  (csr_if)
   );

   lru_cache_scoreboard sb;
   bit                  no_idle  = 1'b0;
   bit                  hold_rsp = 1'b0;
   int unsigned         req_count = 0;
   logic [KEY_W-1:0]    key_pool [POOL_SIZE];
   logic [KEY_W-1:0]    recent_keys [$];

   always #6 clock = ~clock;

   // The result side stalls at random, except in the steady phase or during the hold-off.
   always @(posedge clock) begin
      rsp_if.ready <= !hold_rsp && (no_idle || $urandom_range(99) >= 37);
   end

   // Watch all three channels and feed the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            sb.note_request(req_if.op, req_if.key, req_if.value_in);
            req_count++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_reply(rsp_if.hit, rsp_if.value_out);
         end
         if (csr_if.valid && csr_if.ready) begin
            sb.note_capacity(csr_if.capacity);
         end
      end
   end

   // Once mid-run, the result side holds off long enough that the block backs up.
   initial begin
      wait (req_count >= HOLD_AT_WORD);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Offer one request word after a random gap and wait until it is taken.
   task automatic send_request(input logic op, input logic [KEY_W-1:0] k,
                               input logic [VAL_W-1:0] v);
      while (!no_idle && $urandom_range(99) < 37) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.op       <= op;
      req_if.key      <= k;
      req_if.value_in <= v;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Stop offering, let the monitor note the last accepted word, wait for every
   // owed reply, then let a put still in flight finish.
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] c);
      settle();
      csr_if.valid    <= 1'b1;
      csr_if.capacity <= c;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   // Mostly keys from a fixed pool or from the last four puts, some entirely random keys.
   task automatic send_random_item();
      logic             op;
      logic [KEY_W-1:0] k;
      logic [VAL_W-1:0] v;
      int               pick;
      pick = $urandom_range(99);
      op   = 1'($urandom_range(1));
      v    = VAL_W'($urandom());
      if (pick < 5) begin
         v = '0;
      end else if (pick < 10) begin
         v = '1;
      end
      if (pick >= 90) begin
         k = $urandom();
      end else if (recent_keys.size() != 0 && $urandom_range(1) == 1) begin
         k = recent_keys[$urandom_range(recent_keys.size() - 1)];
      end else begin
         k = key_pool[$urandom_range(POOL_SIZE - 1)];
      end
      send_request(op, k, v);
      if (op == OP_PUT) begin
         recent_keys.push_back(k);
         if (recent_keys.size() > 4) begin
            void'(recent_keys.pop_front());
         end
      end
   endtask

   task automatic run_phase(input logic [CAP_W-1:0] c, input bit steady);
      write_capacity(c);
      no_idle <= steady;
      repeat (PHASE_ITEMS) send_random_item();
      no_idle <= 1'b0;
   endtask

   initial begin
      sb = new();
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.op       <= OP_GET;
      req_if.key      <= '0;
      req_if.value_in <= '0;
      csr_if.valid    <= 1'b0;
      csr_if.capacity <= CAP_RESET;
      foreach (key_pool[i]) begin
         key_pool[i] = $urandom();
      end
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hffff_ffff;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset capacity: miss on an empty store, extreme keys and values, overwrite.
      send_request(OP_GET, 32'h0000_0000, 31'h1234_5678);
      send_request(OP_PUT, 32'h8000_0000, 31'h0000_0000);
      send_request(OP_PUT, 32'h7fff_ffff, 31'h7fff_ffff);
      send_request(OP_PUT, 32'hffff_ffff, 31'h2aaa_aaaa);
      send_request(OP_GET, 32'h8000_0000, 31'h7fff_ffff);
      send_request(OP_GET, 32'h7fff_ffff, 31'h0000_0000);
      send_request(OP_PUT, 32'h8000_0000, 31'h5555_5555);
      send_request(OP_GET, 32'h8000_0000, 31'h0000_0000);
      send_request(OP_GET, 32'h0000_0001, 31'h0000_0000);

      // Capacity lowered below occupancy: each new key evicts exactly one entry.
      write_capacity(5'd2);
      send_request(OP_PUT, 32'h0000_0011, 31'h0000_0001);
      send_request(OP_GET, 32'h7fff_ffff, 31'h0000_0000);
      send_request(OP_GET, 32'hffff_ffff, 31'h0000_0000);
      send_request(OP_PUT, 32'h0000_0022, 31'h0000_0002);
      send_request(OP_GET, 32'h0000_0011, 31'h0000_0000);

      // Capacity zero behaves as capacity one.
      write_capacity(5'd0);
      send_request(OP_PUT, 32'h0000_0033, 31'h0000_0003);
      send_request(OP_GET, 32'h0000_0033, 31'h0000_0000);
      send_request(OP_GET, 32'h0000_0022, 31'h0000_0000);
      send_request(OP_PUT, 32'h0000_0044, 31'h0000_0004);
      send_request(OP_GET, 32'h0000_0033, 31'h0000_0000);

      // Random phases across capacities, the first without any idling.
      run_phase(5'd16, 1'b1);
      run_phase(5'd3,  1'b0);
      run_phase(5'd31, 1'b0);
      run_phase(5'd0,  1'b0);
      run_phase(5'd1,  1'b0);
      run_phase(5'd9,  1'b0);
      run_phase(5'd16, 1'b0);
      run_phase(5'd2,  1'b0);

      settle();
      sb.check_drained();
      if (sb.fault_count == 0) begin
         $display("lru_key_value_cache regression: pass");
      end else begin
         $display("lru_key_value_cache regression: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #3_000_000;
      $display("lru_key_value_cache regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/lkvc_pkg.sv
design/lkvc_if.sv
design/lkvc_ram.sv
design/lkvc_ctrl.sv
design/lru_key_value_cache.sv
tb/lru_key_value_cache_tb.sv
